// ----- rtl/rmat_pkg.sv -----
// rmat_pkg: shared widths, opcodes, FSM states and control/status structs
// for the range max/argmax tree core. No dependencies.
`default_nettype none
package rmat_pkg;
    localparam int VAL_W          = 32;
    localparam int POS_W          = 10;
    localparam int SIZE_W         = 11;
    localparam int MAX_LEAVES_DEF = 1024;
    localparam int TREE_NODES_DEF = 4096;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_POP,
        ST_Q_MERGE,
        ST_U_DESC,
        ST_U_UP,
        ST_U_RD_R,
        ST_U_MERGE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic idle;
        logic clear_step;
        logic accept;
        logic q_pop;
        logic q_merge;
        logic u_desc;
        logic u_up;
        logic u_rd_r;
        logic u_merge;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic stack_empty;
        logic node_hit;
        logic out_of_range;
        logic at_leaf;
        logic at_root;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/rmat_ram.sv -----
// rmat_ram: generic single-port RAM, registered read data.
// No dependencies.
`default_nettype none
module rmat_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/rmat_ctrl.sv -----
// rmat_ctrl: sequencing FSM for clear, update and query walks.
// Depends on rmat_pkg.
`default_nettype none
module rmat_ctrl
    import rmat_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    opcode,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode == OP_QUERY) ? ST_Q_POP : ST_U_DESC;
                end
            end
            ST_Q_POP:
            begin
                if (status.stack_empty)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.node_hit)
                begin
                    state_next = ST_Q_MERGE;
                end
            end
            ST_Q_MERGE:
            begin
                state_next = ST_Q_POP;
            end
            ST_U_DESC:
            begin
                if (status.out_of_range)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.at_leaf)
                begin
                    state_next = status.at_root ? ST_FINISH : ST_U_UP;
                end
            end
            ST_U_UP:
            begin
                state_next = ST_U_RD_R;
            end
            ST_U_RD_R:
            begin
                state_next = ST_U_MERGE;
            end
            ST_U_MERGE:
            begin
                state_next = status.at_root ? ST_FINISH : ST_U_UP;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.idle       = (state_reg == ST_IDLE);
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.accept     = (state_reg == ST_IDLE) && in_valid;
        cmd.q_pop      = (state_reg == ST_Q_POP);
        cmd.q_merge    = (state_reg == ST_Q_MERGE);
        cmd.u_desc     = (state_reg == ST_U_DESC);
        cmd.u_up       = (state_reg == ST_U_UP);
        cmd.u_rd_r     = (state_reg == ST_U_RD_R);
        cmd.u_merge    = (state_reg == ST_U_MERGE);
        cmd.finish     = (state_reg == ST_FINISH) && status.out_free;
    end
endmodule
`default_nettype wire

// ----- rtl/rmat_dp.sv -----
// rmat_dp: datapath with node store, walk stack, accumulator and result register.
// Depends on rmat_pkg and rmat_ram.
`default_nettype none
module rmat_dp
    import rmat_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF,
    parameter int TREE_NODES = TREE_NODES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              cfg_write_en,
    input  wire logic [SIZE_W-1:0] cfg_write_data,
    input  wire logic              opcode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [VAL_W-1:0]  new_value,
    input  wire logic [SIZE_W-1:0] range_low,
    input  wire logic [SIZE_W-1:0] range_high,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   found,
    output logic      [VAL_W-1:0]  max_value,
    output logic      [POS_W-1:0]  max_position
);
    localparam int NODE_AW     = $clog2(TREE_NODES);
    localparam int STACK_DEPTH = $clog2(MAX_LEAVES) + 2;
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int PAIR_W      = VAL_W + POS_W;

    typedef struct packed {
        logic [SIZE_W-1:0]  lo;
        logic [SIZE_W-1:0]  hi;
        logic [NODE_AW-1:0] k;
    } frame_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } pair_t;

    function automatic pair_t pick_max(pair_t a, pair_t b);
        if (a.value != b.value)
        begin
            return (a.value > b.value) ? a : b;
        end
        return (a.pos >= b.pos) ? a : b;
    endfunction

    logic [SIZE_W-1:0]  used_size_reg;
    logic               op_reg;
    logic [POS_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [SIZE_W-1:0]  l_reg, r_reg;
    logic [SIZE_W-1:0]  lo_reg, hi_reg;
    logic [NODE_AW-1:0] k_reg;
    frame_t             stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]    sp_reg;
    logic               acc_valid_reg;
    pair_t              acc_reg;
    pair_t              tmp_reg;
    logic [NODE_AW-1:0] clr_cnt_reg;
    logic               out_valid_reg;

    logic [SIZE_W-1:0]  eff_size;
    logic [SP_W-1:0]    sp_m1;
    frame_t             top;
    logic [SIZE_W-1:0]  top_mid, cur_mid;
    logic               disjoint, contained;
    logic [SIZE_W-1:0]  idx_ext;
    logic [NODE_AW-1:0] parent;
    logic [NODE_AW-1:0] ram_addr;
    logic               ram_we;
    pair_t              ram_wdata, ram_rdata;

    assign eff_size  = (used_size_reg > SIZE_W'(MAX_LEAVES)) ? SIZE_W'(MAX_LEAVES)
                                                              : used_size_reg;
    assign sp_m1     = sp_reg - SP_W'(1);
    assign top       = stack_reg[sp_m1[SIDX_W-1:0]];
    assign top_mid   = SIZE_W'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
    assign cur_mid   = SIZE_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign disjoint  = (top.hi <= l_reg) || (top.lo >= r_reg);
    assign contained = (top.lo >= l_reg) && (top.hi <= r_reg);
    assign idx_ext   = SIZE_W'(idx_reg);
    assign parent    = (k_reg - NODE_AW'(1)) >> 1;

    assign status.clear_last   = (clr_cnt_reg == NODE_AW'(TREE_NODES - 1));
    assign status.stack_empty  = (sp_reg == '0);
    assign status.node_hit     = !disjoint && contained;
    assign status.out_of_range = (idx_ext < lo_reg) || (idx_ext >= hi_reg);
    assign status.at_leaf      = (lo_reg + SIZE_W'(1) == hi_reg);
    assign status.at_root      = (k_reg == '0);
    assign status.out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        ram_addr  = k_reg;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (cmd.clear_step)
        begin
            ram_addr = clr_cnt_reg;
            ram_we   = 1'b1;
        end
        else if (cmd.q_pop)
        begin
            ram_addr = top.k;
        end
        else if (cmd.u_desc)
        begin
            ram_we    = status.at_leaf && !status.out_of_range;
            ram_wdata = '{value: val_reg, pos: idx_reg};
        end
        else if (cmd.u_up)
        begin
            ram_addr = NODE_AW'({parent, 1'b1});
        end
        else if (cmd.u_rd_r)
        begin
            ram_addr = NODE_AW'({k_reg, 1'b0} + (NODE_AW + 1)'(2));
        end
        else if (cmd.u_merge)
        begin
            ram_we    = 1'b1;
            ram_wdata = pick_max(tmp_reg, ram_rdata);
        end
    end

    rmat_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (TREE_NODES)
    ) u_node_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_size_reg <= SIZE_RESET;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                used_size_reg <= cfg_write_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_AW'(1);
            end
            if (cmd.accept)
            begin
                sp_reg        <= SP_W'(1);
                acc_valid_reg <= 1'b0;
            end
            else if (cmd.q_pop && !status.stack_empty)
            begin
                if (!disjoint && !contained)
                begin
                    sp_reg <= sp_reg + SP_W'(1);
                end
                else
                begin
                    sp_reg <= sp_m1;
                end
            end
            else if (cmd.q_merge)
            begin
                acc_valid_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= opcode;
            idx_reg <= position;
            val_reg <= new_value;
            l_reg   <= range_low;
            r_reg   <= range_high;
            lo_reg  <= '0;
            hi_reg  <= eff_size;
            k_reg   <= '0;
            stack_reg[0] <= '{lo: '0, hi: eff_size, k: '0};
        end
        if (cmd.q_pop && !status.stack_empty && !disjoint && !contained)
        begin
            stack_reg[sp_m1[SIDX_W-1:0]] <=
                '{lo: top_mid, hi: top.hi, k: NODE_AW'({top.k, 1'b0} + (NODE_AW + 1)'(2))};
            stack_reg[sp_reg[SIDX_W-1:0]] <=
                '{lo: top.lo, hi: top_mid, k: NODE_AW'({top.k, 1'b1})};
        end
        if (cmd.q_merge)
        begin
            acc_reg <= acc_valid_reg ? pick_max(acc_reg, ram_rdata) : ram_rdata;
        end
        if (cmd.u_desc && !status.at_leaf)
        begin
            if (idx_ext < cur_mid)
            begin
                hi_reg <= cur_mid;
                k_reg  <= NODE_AW'({k_reg, 1'b1});
            end
            else
            begin
                lo_reg <= cur_mid;
                k_reg  <= NODE_AW'({k_reg, 1'b0} + (NODE_AW + 1)'(2));
            end
        end
        if (cmd.u_up)
        begin
            k_reg <= parent;
        end
        if (cmd.u_rd_r)
        begin
            tmp_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            found        <= (op_reg == OP_QUERY) && acc_valid_reg;
            max_value    <= ((op_reg == OP_QUERY) && acc_valid_reg) ? acc_reg.value : '0;
            max_position <= ((op_reg == OP_QUERY) && acc_valid_reg) ? acc_reg.pos : '0;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ----- rtl/range_max_argmax_tree_core.sv -----
// range_max_argmax_tree_core: top level of the range max/argmax segment tree.
// Depends on rmat_pkg, rmat_ctrl, rmat_dp (which holds rmat_ram).
//
// Segment tree of (value, position) pairs over used_size leaves; an update
// writes one leaf and recomputes its path, a query returns the largest pair
// in [range_low, range_high), ties to the larger position. After reset the
// node store is cleared one entry per cycle before the first request is
// taken. One request is in work at a time, all node traffic going through
// the single port of the node RAM: an update is accepted, steps down level
// by level and writes the leaf, then for each level back up moves to the
// parent while reading its left child, reads the right child and writes
// the merged pair, and finishes; a query pops each node it visits, reads
// each stored node it takes into the accumulator, then finishes. A finished
// result waits in the output register while the next request is accepted.
`default_nettype none
module range_max_argmax_tree_core
    import rmat_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF,
    parameter int TREE_NODES = TREE_NODES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [SIZE_W-1:0] cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              opcode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [VAL_W-1:0]  new_value,
    input  wire logic [SIZE_W-1:0] range_low,
    input  wire logic [SIZE_W-1:0] range_high,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   found,
    output logic      [VAL_W-1:0]  max_value,
    output logic      [POS_W-1:0]  max_position
);
    cmd_t    cmd;
    status_t status;

    assign in_stall = !cmd.idle;

    rmat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    rmat_dp #(
        .MAX_LEAVES (MAX_LEAVES),
        .TREE_NODES (TREE_NODES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .position       (position),
        .new_value      (new_value),
        .range_low      (range_low),
        .range_high     (range_high),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .found          (found),
        .max_value      (max_value),
        .max_position   (max_position)
    );
endmodule
`default_nettype wire
